// ===== sv/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// shared types and constants of the clipped stamp blit
// ----------------------------------------------------------------------------
package csb_pkg;

  // item opcodes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_STAMP = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STAMP_WIDTH  = 3'd0,
    REG_STAMP_HEIGHT = 3'd1,
    REG_ANCHOR_X     = 3'd2,
    REG_ANCHOR_Y     = 3'd3,
    REG_DEST_WIDTH   = 3'd4,
    REG_DEST_HEIGHT  = 3'd5
  } reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  // reset values of the registers
  localparam logic [6:0]        RST_STAMP_WIDTH  = 7'd3;
  localparam logic [6:0]        RST_STAMP_HEIGHT = 7'd3;
  localparam logic signed [7:0] RST_ANCHOR       = 8'sd0;
  localparam logic [12:0]       RST_DEST_SIDE    = 13'd4096;

  // stamp store contents after reset: the first rows hold a small square
  localparam int unsigned RESET_ROWS     = 3;
  localparam logic [63:0] RESET_ROW_BITS = 64'h7;

  // signed coordinate wide enough for point minus anchor plus stamp size
  typedef logic signed [15:0] coord_t;

  // clip result of one stamp item
  typedef struct packed {
    logic        empty;
    coord_t      y0;
    coord_t      y_last;
    logic [11:0] col;
    logic [6:0]  len;
    logic [5:0]  sx;
    logic [5:0]  sy;
  } clip_t;

  // row in flight between the store read and the output register
  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [6:0]  len;
    logic [5:0]  sx;
    logic        last;
  } meta_t;

endpackage

// ===== sv/csb_store.sv =====
// ----------------------------------------------------------------------------
// csb_store
// stamp row memory, one write and one registered read port
// ----------------------------------------------------------------------------
module csb_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [63:0]     wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [63:0]     rdata_o
);

  logic [63:0]      mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [63:0]      rdata_q;
  logic             rd_vld_q;
  logic             rd_dflt_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // written rows; an unwritten row reads as its reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_dflt_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q  <= vld_q[raddr_i];
        rd_dflt_q <= raddr_i < IdxW'(csb_pkg::RESET_ROWS);
      end
    end
  end

  always_comb begin
    if (rd_vld_q) begin
      rdata_o = rdata_q;
    end else if (rd_dflt_q) begin
      rdata_o = csb_pkg::RESET_ROW_BITS;
    end else begin
      rdata_o = '0;
    end
  end

endmodule

// ===== sv/csb_clip.sv =====
// ----------------------------------------------------------------------------
// csb_clip
// clips the placed stamp rectangle against the destination grid
// ----------------------------------------------------------------------------
module csb_clip #(
  parameter int unsigned MaxStampSide = 64,
  parameter int unsigned MaxDestSide  = 4096
) (
  input  csb_pkg::coord_t dx_i,
  input  csb_pkg::coord_t dy_i,
  input  logic [6:0]      stamp_width_i,
  input  logic [6:0]      stamp_height_i,
  input  logic [12:0]     dest_width_i,
  input  logic [12:0]     dest_height_i,
  output csb_pkg::clip_t  clip_o
);

  localparam logic [6:0]  StampMax = 7'(MaxStampSide);
  localparam logic [16:0] DestMax  = 17'(MaxDestSide);

  logic [6:0]      w, h;
  logic [12:0]     dw, dh;
  csb_pkg::coord_t x0, x1, xe, y0, y1, ye;
  csb_pkg::coord_t sx, sy, len;

  always_comb begin
    // sizes above the supported maximum saturate
    w  = (stamp_width_i  > StampMax) ? StampMax : stamp_width_i;
    h  = (stamp_height_i > StampMax) ? StampMax : stamp_height_i;
    dw = ({4'd0, dest_width_i}  > DestMax) ? 13'(MaxDestSide) : dest_width_i;
    dh = ({4'd0, dest_height_i} > DestMax) ? 13'(MaxDestSide) : dest_height_i;

    x0 = (dx_i > 16'sd0) ? dx_i : 16'sd0;
    xe = dx_i + csb_pkg::coord_t'({9'd0, w});
    x1 = (xe < csb_pkg::coord_t'({3'd0, dw})) ? xe : csb_pkg::coord_t'({3'd0, dw});
    y0 = (dy_i > 16'sd0) ? dy_i : 16'sd0;
    ye = dy_i + csb_pkg::coord_t'({9'd0, h});
    y1 = (ye < csb_pkg::coord_t'({3'd0, dh})) ? ye : csb_pkg::coord_t'({3'd0, dh});

    sx  = x0 - dx_i;
    sy  = y0 - dy_i;
    len = x1 - x0;

    clip_o.empty  = (w == '0) || (h == '0) || (dw == '0) || (dh == '0) ||
                    (x1 <= x0) || (y1 <= y0);
    clip_o.y0     = y0;
    clip_o.y_last = y1 - 16'sd1;
    clip_o.col    = x0[11:0];
    clip_o.len    = len[6:0];
    clip_o.sx     = sx[5:0];
    clip_o.sy     = sy[5:0];
  end

endmodule

// ===== sv/clipped_stamp_blit_top.sv =====
// ----------------------------------------------------------------------------
// clipped_stamp_blit_top
// stores a binary stamp and emits its clipped rows at a destination point
// ----------------------------------------------------------------------------
// input channel (in_valid_i / in_stall_o): op_i selects a load item, which
// writes row_bits_i to stamp row row_index_i, or a stamp item, which places
// the stamp at point_x_i / point_y_i minus the anchor.
// output channel (out_valid_o / out_stall_i): one item per visible stamp row,
// top to bottom, with destination row and first column, run length and the
// cell bits aligned to that column; last_o marks the final row of a stamp.
// a fully clipped stamp or a zero size gives no output item.
// timing: a load item is written to the store as it is taken. a stamp item
// is clipped in the setup state, then gives one row per cycle while the
// output is not stalled, a rate set by the single read port of the stamp
// memory; each row passes the store read stage and the output register.
// the block takes one item at a time; in_stall_o is high while a stamp item
// is being clipped or its rows are being read out. a stall on the output
// freezes the read pipeline in place; nothing is lost. reset: registers
// return to their defaults and the store reads as a 3x3 square in its top
// rows, zero elsewhere, until rows are loaded. the user writes configuration
// through cfg_we_i while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module clipped_stamp_blit_top #(
  parameter int unsigned MAX_STAMP_SIDE = 64,
  parameter int unsigned MAX_DEST_SIDE  = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [csb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [5:0]                      row_index_i,
  input  logic [63:0]                     row_bits_i,
  input  logic signed [12:0]              point_x_i,
  input  logic signed [12:0]              point_y_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [11:0]                     dest_row_o,
  output logic [11:0]                     dest_col_o,
  output logic [6:0]                      run_length_o,
  output logic [63:0]                     cell_bits_o,
  output logic                            last_o
);

  localparam int unsigned IdxW = $clog2(MAX_STAMP_SIDE);

  // configuration registers
  logic [6:0]        stamp_width_q, stamp_height_q;
  logic signed [7:0] anchor_x_q, anchor_y_q;
  logic [12:0]       dest_width_q, dest_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_width_q  <= csb_pkg::RST_STAMP_WIDTH;
      stamp_height_q <= csb_pkg::RST_STAMP_HEIGHT;
      anchor_x_q     <= csb_pkg::RST_ANCHOR;
      anchor_y_q     <= csb_pkg::RST_ANCHOR;
      dest_width_q   <= csb_pkg::RST_DEST_SIDE;
      dest_height_q  <= csb_pkg::RST_DEST_SIDE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        csb_pkg::REG_STAMP_WIDTH:  stamp_width_q  <= cfg_data_i[6:0];
        csb_pkg::REG_STAMP_HEIGHT: stamp_height_q <= cfg_data_i[6:0];
        csb_pkg::REG_ANCHOR_X:     anchor_x_q     <= cfg_data_i[7:0];
        csb_pkg::REG_ANCHOR_Y:     anchor_y_q     <= cfg_data_i[7:0];
        csb_pkg::REG_DEST_WIDTH:   dest_width_q   <= cfg_data_i;
        csb_pkg::REG_DEST_HEIGHT:  dest_height_q  <= cfg_data_i;
        default: begin
          // unused indexes are dropped
        end
      endcase
    end
  end

  // sequencer
  csb_pkg::state_e state_q, state_d;
  csb_pkg::clip_t  clip;

  logic            in_acc;
  logic            stamp_acc;
  logic            load_we;
  logic            advance;
  logic            issue;
  logic            last_issue;

  // placed origin, captured when the stamp item is taken
  csb_pkg::coord_t dx_q, dx_d, dy_q, dy_d;

  // row walk of the current stamp item
  csb_pkg::coord_t cur_row_q, cur_row_d;
  csb_pkg::coord_t y_last_q, y_last_d;
  logic [IdxW-1:0] srow_q, srow_d;
  logic [11:0]     col_q, col_d;
  logic [6:0]      len_q, len_d;
  logic [5:0]      sx_q, sx_d;

  // read stage and output register
  logic            s1_valid_q, s1_valid_d;
  csb_pkg::meta_t  s1_meta_q, s1_meta_d;
  logic            out_valid_q, out_valid_d;
  logic [11:0]     out_row_q, out_row_d;
  logic [11:0]     out_col_q, out_col_d;
  logic [6:0]      out_len_q, out_len_d;
  logic [63:0]     out_bits_q, out_bits_d;
  logic            out_last_q, out_last_d;

  logic [63:0]     rdata;
  logic [63:0]     run_mask;

  assign in_stall_o = (state_q != csb_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign stamp_acc  = in_acc && (op_i == csb_pkg::OP_STAMP);

  // loads beyond the store depth are ignored
  assign load_we = in_acc && (op_i == csb_pkg::OP_LOAD) &&
                   ({1'b0, row_index_i} < 7'(MAX_STAMP_SIDE));

  // the whole read pipeline moves when the output register can take a row
  assign advance    = !out_valid_q || !out_stall_i;
  assign issue      = (state_q == csb_pkg::ST_RUN) && advance;
  assign last_issue = issue && (cur_row_q == y_last_q);

  csb_clip #(
    .MaxStampSide (MAX_STAMP_SIDE),
    .MaxDestSide  (MAX_DEST_SIDE)
  ) u_clip (
    .dx_i           (dx_q),
    .dy_i           (dy_q),
    .stamp_width_i  (stamp_width_q),
    .stamp_height_i (stamp_height_q),
    .dest_width_i   (dest_width_q),
    .dest_height_i  (dest_height_q),
    .clip_o         (clip)
  );

  csb_store #(
    .Depth (MAX_STAMP_SIDE),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (load_we),
    .waddr_i (row_index_i[IdxW-1:0]),
    .wdata_i (row_bits_i),
    .re_i    (issue),
    .raddr_i (srow_q),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csb_pkg::ST_IDLE: begin
        if (stamp_acc) begin
          state_d = csb_pkg::ST_SETUP;
        end
      end
      csb_pkg::ST_SETUP: begin
        state_d = clip.empty ? csb_pkg::ST_IDLE : csb_pkg::ST_RUN;
      end
      csb_pkg::ST_RUN: begin
        if (last_issue) begin
          state_d = csb_pkg::ST_IDLE;
        end
      end
      default: state_d = csb_pkg::ST_IDLE;
    endcase
  end

  // row walk registers
  always_comb begin
    dx_d      = dx_q;
    dy_d      = dy_q;
    cur_row_d = cur_row_q;
    y_last_d  = y_last_q;
    srow_d    = srow_q;
    col_d     = col_q;
    len_d     = len_q;
    sx_d      = sx_q;
    unique case (state_q)
      csb_pkg::ST_IDLE: begin
        if (stamp_acc) begin
          dx_d = csb_pkg::coord_t'(point_x_i) - csb_pkg::coord_t'(anchor_x_q);
          dy_d = csb_pkg::coord_t'(point_y_i) - csb_pkg::coord_t'(anchor_y_q);
        end
      end
      csb_pkg::ST_SETUP: begin
        cur_row_d = clip.y0;
        y_last_d  = clip.y_last;
        srow_d    = clip.sy[IdxW-1:0];
        col_d     = clip.col;
        len_d     = clip.len;
        sx_d      = clip.sx;
      end
      csb_pkg::ST_RUN: begin
        if (issue) begin
          cur_row_d = cur_row_q + 16'sd1;
          srow_d    = srow_q + IdxW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // pipeline: store read, then align and mask into the output register
  always_comb begin
    s1_valid_d     = s1_valid_q;
    s1_meta_d      = s1_meta_q;
    out_valid_d    = out_valid_q;
    out_row_d      = out_row_q;
    out_col_d      = out_col_q;
    out_len_d      = out_len_q;
    out_bits_d     = out_bits_q;
    out_last_d     = out_last_q;
    run_mask       = s1_meta_q.len[6] ? '1 : ((64'd1 << s1_meta_q.len[5:0]) - 64'd1);
    if (advance) begin
      s1_valid_d     = issue;
      s1_meta_d.row  = cur_row_q[11:0];
      s1_meta_d.col  = col_q;
      s1_meta_d.len  = len_q;
      s1_meta_d.sx   = sx_q;
      s1_meta_d.last = last_issue;
      out_valid_d    = s1_valid_q;
      out_row_d      = s1_meta_q.row;
      out_col_d      = s1_meta_q.col;
      out_len_d      = s1_meta_q.len;
      out_bits_d     = (rdata >> s1_meta_q.sx) & run_mask;
      out_last_d     = s1_meta_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csb_pkg::ST_IDLE;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    cur_row_q  <= cur_row_d;
    y_last_q   <= y_last_d;
    srow_q     <= srow_d;
    col_q      <= col_d;
    len_q      <= len_d;
    sx_q       <= sx_d;
    s1_meta_q  <= s1_meta_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_len_q  <= out_len_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign dest_row_o   = out_row_q;
  assign dest_col_o   = out_col_q;
  assign run_length_o = out_len_q;
  assign cell_bits_o  = out_bits_q;
  assign last_o       = out_last_q;

endmodule

// ===== sv/csb_checker.sv =====
// ----------------------------------------------------------------------------
// csb_checker
// port-level checks of the clipped stamp blit
// ----------------------------------------------------------------------------
module csb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        op_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] dest_row_o,
  input logic [6:0]  run_length_o,
  input logic [63:0] cell_bits_o,
  input logic        last_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(dest_row_o) && $stable(cell_bits_o) && $stable(last_o))
    else $error("stalled result item changed");

  // run length stays within the stamp width range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_length_o != 7'd0) && (run_length_o <= 7'd64))
    else $error("run length out of range");

  // no cell bits beyond the run
  a_bits_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (run_length_o < 7'd64) |-> ((cell_bits_o >> run_length_o) == 64'd0))
    else $error("cell bits beyond run length");

  // a taken stamp item blocks the input in the next cycle
  a_stamp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == csb_pkg::OP_STAMP) |=> in_stall_o)
    else $error("input not held off after stamp item");

endmodule

bind clipped_stamp_blit_top csb_checker u_csb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .op_i         (op_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .dest_row_o   (dest_row_o),
  .run_length_o (run_length_o),
  .cell_bits_o  (cell_bits_o),
  .last_o       (last_o)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the clipped stamp blit: a queue-fed driver sends
// load and stamp items in random bursts, a predictor clips each stamp against
// the destination grid and queues the rows it must produce, and a monitor
// checks every output item field by field while the receiver stalls on its
// own pattern; the configuration changes between phases while idle
// ----------------------------------------------------------------------------
module testbench;

  // one input item waiting in the driver queue
  typedef struct {
    csb_pkg::op_e       op;
    logic [5:0]         row_index;
    logic [63:0]        row_bits;
    logic signed [12:0] px;
    logic signed [12:0] py;
    bit                 drain;    // hold off until every expected row is out
  } blit_item_t;

  // one clipped stamp row as it should leave the block
  typedef struct {
    logic [11:0] dest_row;
    logic [11:0] dest_col;
    logic [6:0]  run_length;
    logic [63:0] cell_bits;
    logic        is_last;
  } stamp_run_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic                            cfg_we = 1'b0;
  logic [csb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // input channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op_in = csb_pkg::OP_LOAD;
  logic [5:0]         row_index = '0;
  logic [63:0]        row_bits = '0;
  logic signed [12:0] point_x = '0;
  logic signed [12:0] point_y = '0;

  // output channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] dest_row;
  logic [11:0] dest_col;
  logic [6:0]  run_length;
  logic [63:0] cell_bits;
  logic        last;

  clipped_stamp_blit_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op_in),
    .row_index_i  (row_index),
    .row_bits_i   (row_bits),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .dest_row_o   (dest_row),
    .dest_col_o   (dest_col),
    .run_length_o (run_length),
    .cell_bits_o  (cell_bits),
    .last_o       (last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow state of the block: stamp store and configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0]        stamp_store [64];
  logic [6:0]         stamp_w_q = csb_pkg::RST_STAMP_WIDTH;
  logic [6:0]         stamp_h_q = csb_pkg::RST_STAMP_HEIGHT;
  logic signed [7:0]  anchor_x_q = csb_pkg::RST_ANCHOR;
  logic signed [7:0]  anchor_y_q = csb_pkg::RST_ANCHOR;
  logic [12:0]        dest_w_q = csb_pkg::RST_DEST_SIDE;
  logic [12:0]        dest_h_q = csb_pkg::RST_DEST_SIDE;

  initial begin
    for (int i = 0; i < 64; i++) begin
      stamp_store[i] = (i < csb_pkg::RESET_ROWS) ? csb_pkg::RESET_ROW_BITS : '0;
    end
  end

  blit_item_t items_pending[$];
  stamp_run_t runs_due[$];

  int errors = 0;
  int loads_taken = 0;
  int stamps_taken = 0;
  int empty_stamps = 0;
  int runs_checked = 0;

  // sizes after saturation, as the block sees them
  function automatic int stamp_w_eff();
    return (stamp_w_q > 64) ? 64 : int'(stamp_w_q);
  endfunction

  function automatic int stamp_h_eff();
    return (stamp_h_q > 64) ? 64 : int'(stamp_h_q);
  endfunction

  function automatic int dest_w_eff();
    return (dest_w_q > 4096) ? 4096 : int'(dest_w_q);
  endfunction

  function automatic int dest_h_eff();
    return (dest_h_q > 4096) ? 4096 : int'(dest_h_q);
  endfunction

  // clip one stamp at a point and queue the visible rows, top to bottom
  function automatic void predict_stamp_runs(logic signed [12:0] px, logic signed [12:0] py);
    int w, h, dw, dh, dx, dy, x0, x1, y0, y1, sx, sy, len;
    logic [63:0] mask;
    stamp_run_t run;
    w = stamp_w_eff();
    h = stamp_h_eff();
    dw = dest_w_eff();
    dh = dest_h_eff();
    stamps_taken++;
    // a zero stamp or destination side gives nothing
    if (w == 0 || h == 0 || dw == 0 || dh == 0) begin
      empty_stamps++;
      return;
    end
    dx = int'(px) - int'(anchor_x_q);
    dy = int'(py) - int'(anchor_y_q);
    x0 = (dx > 0) ? dx : 0;
    x1 = (dx + w < dw) ? dx + w : dw;
    y0 = (dy > 0) ? dy : 0;
    y1 = (dy + h < dh) ? dy + h : dh;
    // stamp entirely outside the grid
    if (x1 <= x0 || y1 <= y0) begin
      empty_stamps++;
      return;
    end
    sx = x0 - dx;
    sy = y0 - dy;
    len = x1 - x0;
    mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
    for (int r = y0; r < y1; r++) begin
      run.dest_row   = 12'(r);
      run.dest_col   = 12'(x0);
      run.run_length = 7'(len);
      run.cell_bits  = (stamp_store[(sy + r - y0) & 63] >> sx) & mask;
      run.is_last    = (r == y1 - 1);
      runs_due.push_back(run);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: tracks accepted input items and checks output items
  // ---------------------------------------------------------------------------
  logic in_taken = 1'b0;
  stamp_run_t run_exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (op_in == csb_pkg::OP_LOAD) begin
          stamp_store[row_index] = row_bits;
          loads_taken++;
        end else begin
          predict_stamp_runs(point_x, point_y);
        end
      end
      if (out_valid && !out_stall) begin
        if (runs_due.size() == 0) begin
          $error("unexpected output item: row %0d col %0d", dest_row, dest_col);
          errors++;
        end else begin
          run_exp = runs_due.pop_front();
          runs_checked++;
          if (dest_row !== run_exp.dest_row) begin
            $error("dest_row: expected %0d, got %0d", run_exp.dest_row, dest_row);
            errors++;
          end
          if (dest_col !== run_exp.dest_col) begin
            $error("dest_col: expected %0d, got %0d", run_exp.dest_col, dest_col);
            errors++;
          end
          if (run_length !== run_exp.run_length) begin
            $error("run_length: expected %0d, got %0d", run_exp.run_length, run_length);
            errors++;
          end
          if (cell_bits !== run_exp.cell_bits) begin
            $error("cell_bits: expected %h, got %h", run_exp.cell_bits, cell_bits);
            errors++;
          end
          if (last !== run_exp.is_last) begin
            $error("last: expected %0b, got %0b", run_exp.is_last, last);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: pops items from the queue in bursts with random gaps between them
  // ---------------------------------------------------------------------------
  blit_item_t item_now;
  logic valid_next;
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    // a stalled item stays on the bus unchanged
    valid_next = in_valid && !in_taken;
    if (!valid_next && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (items_pending.size() != 0 &&
                   !(items_pending[0].drain && runs_due.size() != 0)) begin
        item_now = items_pending.pop_front();
        op_in     <= item_now.op;
        row_index <= item_now.row_index;
        row_bits  <= item_now.row_bits;
        point_x   <= item_now.px;
        point_y   <= item_now.py;
        valid_next = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // a third of the bursts run straight on without a gap
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
    end
    in_valid <= valid_next;
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern cycles through quiet, random, periodic and heavy
  // ---------------------------------------------------------------------------
  int stall_cycle = 0;

  always @(negedge clk) begin
    stall_cycle++;
    case ((stall_cycle / 300) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ((stall_cycle % 7) < 3);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_load(logic [5:0] idx, logic [63:0] bits);
    blit_item_t it;
    it.op = csb_pkg::OP_LOAD;
    it.row_index = idx;
    it.row_bits = bits;
    it.px = 13'($urandom);
    it.py = 13'($urandom);
    it.drain = 1'b0;
    items_pending.push_back(it);
  endfunction

  function automatic void push_stamp(int px, int py, bit drain);
    blit_item_t it;
    it.op = csb_pkg::OP_STAMP;
    it.row_index = 6'($urandom);
    it.row_bits = {$urandom, $urandom};
    it.px = 13'(px);
    it.py = 13'(py);
    it.drain = drain;
    items_pending.push_back(it);
  endfunction

  // coordinate near the visible area most of the time, anywhere otherwise
  function automatic int aim_coord(int anchor, int side, int dest);
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 8191)) - 4096;
    return anchor - side - 2 + int'($urandom_range(0, dest + side + 4));
  endfunction

  // waits until the block has nothing left to do
  task automatic wait_drained();
    while (items_pending.size() != 0 || in_valid || runs_due.size() != 0) @(posedge clk);
    // a fully clipped stamp still occupies the block after the queues are empty
    repeat (70) @(posedge clk);
  endtask

  // writes all six registers, one per cycle, and keeps the shadow copies
  task automatic set_config(int sw, int sh, int ax, int ay, int dw, int dh);
    csb_pkg::reg_e idx;
    int value;
    for (int i = 0; i < 6; i++) begin
      idx = csb_pkg::reg_e'(i);
      case (idx)
        csb_pkg::REG_STAMP_WIDTH:  value = sw;
        csb_pkg::REG_STAMP_HEIGHT: value = sh;
        csb_pkg::REG_ANCHOR_X:     value = ax;
        csb_pkg::REG_ANCHOR_Y:     value = ay;
        csb_pkg::REG_DEST_WIDTH:   value = dw;
        default:                   value = dh;
      endcase
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value[csb_pkg::CFG_DATA_W-1:0];
      case (idx)
        csb_pkg::REG_STAMP_WIDTH:  stamp_w_q = 7'(value);
        csb_pkg::REG_STAMP_HEIGHT: stamp_h_q = 7'(value);
        csb_pkg::REG_ANCHOR_X:     anchor_x_q = 8'(value);
        csb_pkg::REG_ANCHOR_Y:     anchor_y_q = 8'(value);
        csb_pkg::REG_DEST_WIDTH:   dest_w_q = 13'(value);
        default:                   dest_h_q = 13'(value);
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one configuration phase: drain, reprogram, then a mix of loads and stamps
  task automatic run_phase(int sw, int sh, int ax, int ay, int dw, int dh, int n_items);
    logic [63:0] bits;
    wait_drained();
    set_config(sw, sh, ax, ay, dw, dh);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        case ($urandom_range(0, 7))
          0:       bits = '1;
          1:       bits = '0;
          default: bits = {$urandom, $urandom};
        endcase
        push_load(6'($urandom_range(0, 63)), bits);
      end else begin
        // now and then the sender waits for the block to empty first
        push_stamp(aim_coord(int'(anchor_x_q), stamp_w_eff(), dest_w_eff()),
                   aim_coord(int'(anchor_y_q), stamp_h_eff(), dest_h_eff()),
                   (i == n_items / 2) || ($urandom_range(0, 39) == 0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset contents of the store with the reset 3x3 stamp
    push_stamp(0, 0, 1'b0);
    push_stamp(-1, -1, 1'b0);          // clipped on the top left
    push_stamp(4094, 4094, 1'b0);      // clipped on the bottom right
    push_stamp(4095, 4095, 1'b0);      // single visible cell
    push_stamp(-4096, -4096, 1'b0);    // fully clipped
    push_stamp(-3, 0, 1'b0);           // right edge just outside
    push_stamp(4095, -4096, 1'b0);     // fully clipped, mixed extremes
    push_stamp(0, 4096 - 3, 1'b0);     // touches the bottom edge exactly
    // extreme row contents
    push_load(6'd0, '1);
    push_load(6'd1, '0);
    push_load(6'd2, 64'haaaa_aaaa_aaaa_aaaa);
    push_load(6'd63, '1);
    push_load(6'd62, 64'h5555_5555_5555_5555);
    push_stamp(100, 200, 1'b1);
    push_stamp(-2, 4093, 1'b0);
    push_stamp(4093, -2, 1'b0);
    push_load(6'd3, 64'h8000_0000_0000_0001);
    push_stamp(2047, 2048, 1'b0);

    // full-size stamp, negative horizontal anchor
    run_phase(64, 64, -64, 64, 4096, 4096, 40);
    // small stamp, most negative and most positive anchors, small grid
    run_phase(8, 5, -128, 127, 40, 30, 60);
    // oversized stamp width and destination width saturate
    run_phase(127, 2, 127, -128, 8191, 100, 50);
    // zero sides give nothing
    run_phase(0, 4, 0, 0, 50, 50, 15);
    run_phase(5, 0, 0, 0, 50, 50, 15);
    run_phase(6, 6, 3, -3, 0, 20, 15);
    run_phase(6, 6, 0, 0, 20, 0, 15);
    // smallest stamp on the smallest grid
    run_phase(1, 1, 0, 0, 1, 1, 30);
    run_phase(16, 12, -5, 7, 64, 48, 80);
    run_phase(33, 20, 10, -10, 4096, 4096, 60);
    for (int p = 0; p < 2; p++) begin
      run_phase($urandom_range(1, 64), $urandom_range(1, 16),
                int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
                $urandom_range(1, 200), $urandom_range(1, 200), 40);
    end
    // back to the reset settings
    run_phase(csb_pkg::RST_STAMP_WIDTH, csb_pkg::RST_STAMP_HEIGHT, 0, 0,
              csb_pkg::RST_DEST_SIDE, csb_pkg::RST_DEST_SIDE, 20);

    wait_drained();
    $display("covered %0d row loads and %0d stamps, %0d of them fully clipped or empty,",
             loads_taken, stamps_taken, empty_stamps);
    $display("with %0d output rows checked over 14 register settings", runs_checked);
    if (errors == 0 && runs_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #20ms;
    $display("timeout with %0d output rows still due", runs_due.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/csb_pkg.sv
sv/csb_store.sv
sv/csb_clip.sv
sv/clipped_stamp_blit_top.sv
sv/csb_checker.sv
test/testbench.sv
